@@ sv/pvd_pkg.sv @@
// Package for the population vector decoder.
// Holds sizes, register indexes, the CORDIC arctangent table and the
// preferred-direction cosine/sine table. No dependencies.
package pvd_pkg;

   localparam int NEURONS   = 16;
   localparam int RATE_BITS = 16;

   localparam int RATE_W  = 16;
   localparam int IDX_W   = 4;
   localparam int DATA_W  = 16;
   localparam int ACC_W   = 37;
   localparam int TOTAL_W = 20;

   localparam logic [RATE_W-1:0] RATE_MASK =
      (RATE_BITS >= RATE_W) ? {RATE_W{1'b1}} : RATE_W'((32'd1 << RATE_BITS) - 32'd1);

   localparam logic CSR_MIN_RATE        = 1'b0;
   localparam logic CSR_DIVIDE_BY_TOTAL = 1'b1;

   localparam logic [15:0] MIN_RATE_RESET = 16'd655;

   typedef logic [13:0] atan_table_type [16];
   localparam atan_table_type ATAN_UNITS = '{
      14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
      14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
   };

   typedef logic [15:0][31:0] cs_table_type;

   // Q1.15 cosine or sine of neuron idx by a 16-step rotation CORDIC
   function automatic logic [15:0] cs_q15(input int unsigned idx, input bit want_sin);
      longint z;
      longint x;
      longint y;
      longint t;
      longint r;
      bit     neg;
      z   = longint'((idx * 65536) / NEURONS) & 64'hFFFF;
      x   = 64'sd652032875;
      y   = 0;
      neg = 1'b0;
      if (z >= 32768) z = z - 65536;
      if (z > 16384) begin
         z   = z - 32768;
         neg = 1'b1;
      end else if (z < -16384) begin
         z   = z + 32768;
         neg = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         t = x;
         if (z >= 0) begin
            x = x - (y >>> i);
            y = y + (t >>> i);
            z = z - longint'(ATAN_UNITS[i]);
         end else begin
            x = x + (y >>> i);
            y = y - (t >>> i);
            z = z + longint'(ATAN_UNITS[i]);
         end
      end
      if (neg) begin
         x = -x;
         y = -y;
      end
      r = ((want_sin ? y : x) + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return 16'(r);
   endfunction

   function automatic cs_table_type build_cs_table();
      cs_table_type tbl;
      tbl = '0;
      for (int unsigned i = 0; i < 16; i++) begin
         if (i < NEURONS) tbl[i] = {cs_q15(i, 1'b0), cs_q15(i, 1'b1)};
      end
      return tbl;
   endfunction

   localparam cs_table_type CS_TABLE = build_cs_table();

endpackage

@@ sv/population_vector_decoder_top.sv @@
// Population vector decoder: accumulates rate-weighted direction vectors and
// decodes angle and normalized length through one shared sequenced datapath.
// Depends on pvd_pkg.
//
//   channel  ports                                        transfer when
//   input    start, busy, req_rate/neuron_index/last      start & !busy
//   result   rsp_strobe, rsp_direction/magnitude/valid_res rsp_strobe
//   config   csr_write_enable, csr_index, csr_write_data  csr_write_enable
//
// A non-final item passes through accept, cosine product and sine product on one
// multiplier. A final item adds squaring, 16 CORDIC steps, 30 root steps and
// 38 divide steps before the result strobe, or strobes after the S_SQ_X check
// when the total is at or below the threshold. Synchronous reset loads register
// defaults and clears the accumulators. Result shown for one cycle; no stall.
module population_vector_decoder_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [pvd_pkg::RATE_W-1:0] req_rate,
   input  logic [pvd_pkg::IDX_W-1:0]  req_neuron_index,
   input  logic                       req_last,
   output logic                       rsp_strobe,
   output logic signed [15:0]         rsp_direction,
   output logic [15:0]                rsp_magnitude,
   output logic                       rsp_valid_res,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [pvd_pkg::DATA_W-1:0] csr_write_data
);
   import pvd_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL_C = 3'd1;
   localparam logic [2:0] S_MUL_S = 3'd2;
   localparam logic [2:0] S_SQ_X  = 3'd3;
   localparam logic [2:0] S_SQ_Y  = 3'd4;
   localparam logic [2:0] S_CORD  = 3'd5;
   localparam logic [2:0] S_ROOT  = 3'd6;
   localparam logic [2:0] S_DIV   = 3'd7;

   localparam logic [5:0] CORD_LAST = 6'd15;
   localparam logic [5:0] ROOT_LAST = 6'd29;
   localparam logic [5:0] DIV_LAST  = 6'd37;
   localparam logic [TOTAL_W-1:0] CNT_DIV = TOTAL_W'(256 * NEURONS);

   logic [2:0]               state_ff, state_in;
   logic [15:0]              min_rate_ff, min_rate_in;
   logic                     div_total_ff, div_total_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [31:0]              cs_ff, cs_in;
   logic                     hit_ff, hit_in;
   logic                     last_ff, last_in;
   logic signed [ACC_W-1:0]  sum_cos_ff, sum_cos_in;
   logic signed [ACC_W-1:0]  sum_sin_ff, sum_sin_in;
   logic [TOTAL_W-1:0]       total_ff, total_in;
   logic signed [33:0]       cx_ff, cx_in;
   logic signed [33:0]       cy_ff, cy_in;
   logic signed [17:0]       cz_ff, cz_in;
   logic                     zv_ff, zv_in;
   logic [5:0]               step_ff, step_in;
   logic [59:0]              sq_ff, sq_in;
   logic [33:0]              rem_ff, rem_in;
   logic [29:0]              root_ff, root_in;
   logic [37:0]              num_ff, num_in;
   logic [TOTAL_W-1:0]       drem_ff, drem_in;
   logic                     strobe_ff, strobe_in;
   logic signed [15:0]       dir_ff, dir_in;
   logic [15:0]              mag_ff, mag_in;
   logic                     vres_ff, vres_in;

   logic [RATE_W-1:0]        rate_m;
   logic signed [30:0]       mul_a, mul_b;
   logic signed [61:0]       prod;
   logic signed [ACC_W:0]    acc_sum;
   logic signed [ACC_W-1:0]  acc_sat;
   logic signed [ACC_W-1:0]  acc_cur;
   logic [TOTAL_W:0]         tot_sum;
   logic signed [29:0]       xs, ys;
   logic signed [33:0]       xe, ye;
   logic [3:0]               shamt;
   logic signed [33:0]       cx_sh, cy_sh;
   logic signed [17:0]       atan_v;
   logic                     y_pos;
   logic [33:0]              rem_next, trial;
   logic [TOTAL_W:0]         drem_next;
   logic [TOTAL_W-1:0]       divisor;

   assign busy          = (state_ff != S_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_direction = dir_ff;
   assign rsp_magnitude = mag_ff;
   assign rsp_valid_res = vres_ff;

   assign rate_m = req_rate & RATE_MASK;

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         S_MUL_C: begin
            mul_a = signed'({15'd0, rate_ff});
            mul_b = 31'(signed'(cs_ff[31:16]));
         end
         S_MUL_S: begin
            mul_a = signed'({15'd0, rate_ff});
            mul_b = 31'(signed'(cs_ff[15:0]));
         end
         S_SQ_X: begin
            mul_a = 31'(xs);
            mul_b = 31'(xs);
         end
         S_SQ_Y: begin
            mul_a = 31'(ys);
            mul_b = 31'(ys);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   assign acc_cur = (state_ff == S_MUL_C) ? sum_cos_ff : sum_sin_ff;
   assign acc_sum = {acc_cur[ACC_W-1], acc_cur} + prod[ACC_W:0];
   always_comb begin
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
         acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
         acc_sat = acc_sum[ACC_W-1:0];
   end
   assign tot_sum = {1'b0, total_ff} + (TOTAL_W+1)'(rate_ff);

   assign xs = sum_cos_ff[ACC_W-1:7];
   assign ys = sum_sin_ff[ACC_W-1:7];
   assign xe = {{4{xs[29]}}, xs};
   assign ye = {{4{ys[29]}}, ys};

   assign shamt  = step_ff[3:0];
   assign cx_sh  = cx_ff >>> shamt;
   assign cy_sh  = cy_ff >>> shamt;
   assign atan_v = signed'({4'd0, ATAN_UNITS[shamt]});
   assign y_pos  = !cy_ff[33] && (cy_ff != '0);

   assign rem_next = {rem_ff[31:0], sq_ff[59:58]};
   assign trial    = {2'b00, root_ff, 2'b01};

   assign divisor   = div_total_ff ? total_ff : CNT_DIV;
   assign drem_next = {drem_ff, num_ff[37]};

   always_comb begin
      state_in     = state_ff;
      min_rate_in  = min_rate_ff;
      div_total_in = div_total_ff;
      rate_in      = rate_ff;
      cs_in        = cs_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      sum_cos_in   = sum_cos_ff;
      sum_sin_in   = sum_sin_ff;
      total_in     = total_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      zv_in        = zv_ff;
      step_in      = step_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      num_in       = num_ff;
      drem_in      = drem_ff;
      strobe_in    = 1'b0;
      dir_in       = dir_ff;
      mag_in       = mag_ff;
      vres_in      = vres_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_RATE:        min_rate_in  = csr_write_data;
            CSR_DIVIDE_BY_TOTAL: div_total_in = csr_write_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rate_in  = rate_m;
               cs_in    = CS_TABLE[req_neuron_index];
               hit_in   = (rate_m > min_rate_ff) && (32'(req_neuron_index) < NEURONS);
               last_in  = req_last;
               state_in = S_MUL_C;
            end
         end
         S_MUL_C: begin
            if (hit_ff) sum_cos_in = acc_sat;
            state_in = S_MUL_S;
         end
         S_MUL_S: begin
            if (hit_ff) begin
               sum_sin_in = acc_sat;
               total_in   = tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];
            end
            state_in = last_ff ? S_SQ_X : S_IDLE;
         end
         S_SQ_X: begin
            if (total_ff > TOTAL_W'(min_rate_ff)) begin
               sq_in   = 60'(prod);
               zv_in   = (xs == '0) && (ys == '0);
               step_in = '0;
               if (xs[29]) begin
                  if (!ys[29]) begin
                     cx_in = ye;
                     cy_in = -xe;
                     cz_in = 18'sd16384;
                  end else begin
                     cx_in = -ye;
                     cy_in = xe;
                     cz_in = -18'sd16384;
                  end
               end else begin
                  cx_in = xe;
                  cy_in = ye;
                  cz_in = '0;
               end
               state_in = S_SQ_Y;
            end else begin
               strobe_in  = 1'b1;
               dir_in     = '0;
               mag_in     = '0;
               vres_in    = 1'b0;
               sum_cos_in = '0;
               sum_sin_in = '0;
               total_in   = '0;
               state_in   = S_IDLE;
            end
         end
         S_SQ_Y: begin
            sq_in    = sq_ff + 60'(prod);
            state_in = S_CORD;
         end
         S_CORD: begin
            if (y_pos) begin
               cx_in = cx_ff + cy_sh;
               cy_in = cy_ff - cx_sh;
               cz_in = cz_ff + atan_v;
            end else begin
               cx_in = cx_ff - cy_sh;
               cy_in = cy_ff + cx_sh;
               cz_in = cz_ff - atan_v;
            end
            if (step_ff == CORD_LAST) begin
               step_in  = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = S_ROOT;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         S_ROOT: begin
            sq_in = {sq_ff[57:0], 2'b00};
            if (rem_next >= trial) begin
               rem_in  = rem_next - trial;
               root_in = {root_ff[28:0], 1'b1};
            end else begin
               rem_in  = rem_next;
               root_in = {root_ff[28:0], 1'b0};
            end
            if (step_ff == ROOT_LAST) begin
               step_in  = '0;
               drem_in  = '0;
               num_in   = div_total_ff ? {root_in, 8'd0} : {8'd0, root_in};
               state_in = S_DIV;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         S_DIV: begin
            if (drem_next >= {1'b0, divisor}) begin
               drem_in = TOTAL_W'(drem_next - {1'b0, divisor});
               num_in  = {num_ff[36:0], 1'b1};
            end else begin
               drem_in = drem_next[TOTAL_W-1:0];
               num_in  = {num_ff[36:0], 1'b0};
            end
            if (step_ff == DIV_LAST) begin
               strobe_in  = 1'b1;
               dir_in     = zv_ff ? 16'sd0 : cz_ff[15:0];
               mag_in     = (num_in[37:16] != '0) ? 16'hFFFF : num_in[15:0];
               vres_in    = 1'b1;
               sum_cos_in = '0;
               sum_sin_in = '0;
               total_in   = '0;
               step_in    = '0;
               state_in   = S_IDLE;
            end else begin
               step_in = step_ff + 6'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_rate_ff  <= MIN_RATE_RESET;
         div_total_ff <= 1'b1;
         sum_cos_ff   <= '0;
         sum_sin_ff   <= '0;
         total_ff     <= '0;
         step_ff      <= '0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_rate_ff  <= min_rate_in;
         div_total_ff <= div_total_in;
         sum_cos_ff   <= sum_cos_in;
         sum_sin_ff   <= sum_sin_in;
         total_ff     <= total_in;
         step_ff      <= step_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
      cs_ff   <= cs_in;
      hit_ff  <= hit_in;
      last_ff <= last_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      zv_ff   <= zv_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      drem_ff <= drem_in;
      dir_ff  <= dir_in;
      mag_ff  <= mag_in;
      vres_ff <= vres_in;
   end

endmodule

@@ sv/pvd_checker.sv @@
// Port-level checker for the population vector decoder, bound to the top.
// Depends on pvd_pkg.
module pvd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [pvd_pkg::RATE_W-1:0] req_rate,
   input logic [pvd_pkg::IDX_W-1:0]  req_neuron_index,
   input logic                       req_last,
   input logic                       rsp_strobe,
   input logic signed [15:0]         rsp_direction,
   input logic [15:0]                rsp_magnitude,
   input logic                       rsp_valid_res
);
   import pvd_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transfer did not raise busy");

   a_request_known: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> !$isunknown({req_rate, req_neuron_index, req_last}))
      else $error("request fields unknown at transfer");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_valid_res |-> rsp_direction == 16'sd0 && rsp_magnitude == 16'd0)
      else $error("invalid result carries nonzero fields");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) && !busy)
      else $error("result transfer without preceding work");

endmodule

bind population_vector_decoder_top pvd_checker u_pvd_checker (.*);
